[design/ptsn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptsn_pkg: shared types and widths for the segment nearest-point block
// Coordinate, product and quotient widths, the status codes and the layout
// of the item that passes from the front end to the back end.
// ----------------------------------------------------------------------------
package ptsn_pkg;

	localparam int CW    = 24;          // coordinate width, signed fixed point
	localparam int TOLW  = CW - 1;      // tolerance register width
	localparam int DW    = CW + 1;      // width of a coordinate difference
	localparam int DENW  = 2 * DW;      // |B-A|^2, unsigned
	localparam int NUMW  = DENW + 1;    // (P-A).(B-A), signed
	localparam int HW    = DENW / 2;    // half of the numerator for the split product
	localparam int TW    = CW + DENW;   // |D| * num
	localparam int NWID  = TW + 1;      // dividend 2*|D|*num + den
	localparam int DVW   = DENW + 1;    // divisor 2*den
	localparam int RW    = CW + 1;      // root width
	localparam int SQW   = 2 * RW;      // squared distance
	localparam int QAW   = 1;           // queue address width
	localparam int QDEPTH = 1 << QAW;
	localparam int QCW   = QAW + 1;

	typedef logic signed [CW-1:0] coord_t;
	typedef coord_t [2:0] vec_t;

	typedef enum logic [1:0] {
		ST_DEGEN    = 2'd0,
		ST_ENDPOINT = 2'd1,
		ST_FOOT     = 2'd2
	} status_t;

	// Item handed from the front end to the back end through the queue.
	typedef struct packed {
		status_t               status;
		vec_t                  base;    // A, B or zero; the foot starts from A
		vec_t                  query;
		logic [2:0]            d_neg;
		logic [2:0][CW-1:0]    d_mag;
		logic [DENW-1:0]       num;
		logic [DENW-1:0]       den;
	} qent_t;

endpackage
`default_nettype wire

[design/ptsn_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptsn_if: channel interfaces of the segment nearest-point block
// Query, result and configuration channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface ptsn_query_if import ptsn_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t seg_a_x, seg_a_y, seg_a_z;
	coord_t seg_b_x, seg_b_y, seg_b_z;
	coord_t query_x, query_y, query_z;
	modport source (output valid, seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z,
		query_x, query_y, query_z, input ready);
	modport sink (input valid, seg_a_x, seg_a_y, seg_a_z, seg_b_x, seg_b_y, seg_b_z,
		query_x, query_y, query_z, output ready);
endinterface

interface ptsn_result_if import ptsn_pkg::*; ();
	logic          valid;
	logic          ready;
	status_t       status;
	coord_t        near_x, near_y, near_z;
	logic [CW:0]   min_distance;
	modport source (output valid, status, near_x, near_y, near_z, min_distance, input ready);
	modport sink (input valid, status, near_x, near_y, near_z, min_distance, output ready);
endinterface

interface ptsn_cfg_if import ptsn_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [TOLW-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[design/ptsn_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptsn_front: accept and classify
// Forms B-A and P-A, the dot products, the degenerate test and the position
// of the projection relative to the segment, in four stages.
// ----------------------------------------------------------------------------
module ptsn_front import ptsn_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	ptsn_query_if.sink  query,
	ptsn_cfg_if.sink    cfg,
	output qent_t       ent,
	output logic        ent_valid,
	input  logic        ent_ready
);

	logic            en;
	logic [TOLW-1:0] tol_q;

	coord_t in_a [3], in_b [3], in_p [3];

	logic                   v_s1, v_s2, v_s3, v_s4;
	coord_t                 a_s1 [3], b_s1 [3], p_s1 [3];
	logic signed [DW-1:0]   d_s1 [3], pa_s1 [3];
	logic [DW-1:0]          dmag [3];

	coord_t                 a_s2 [3], b_s2 [3], p_s2 [3];
	logic signed [DENW-1:0] dd_s2 [3], pd_s2 [3];
	logic [CW-1:0]          dm_s2 [3];
	logic [2:0]             dn_s2;
	logic                   small_s2, zero_s2;

	coord_t                 a_s3 [3], b_s3 [3], p_s3 [3];
	logic [CW-1:0]          dm_s3 [3];
	logic [2:0]             dn_s3;
	logic [DENW-1:0]        den_s3;
	logic signed [NUMW-1:0] num_s3;
	logic                   degen_s3;

	qent_t                  ent_s4;

	assign en          = !v_s4 || ent_ready;
	assign query.ready = en;
	assign cfg.ready   = 1'b1;
	assign ent         = ent_s4;
	assign ent_valid   = v_s4;

	always_comb begin
		in_a[0] = query.seg_a_x; in_a[1] = query.seg_a_y; in_a[2] = query.seg_a_z;
		in_b[0] = query.seg_b_x; in_b[1] = query.seg_b_y; in_b[2] = query.seg_b_z;
		in_p[0] = query.query_x; in_p[1] = query.query_y; in_p[2] = query.query_z;
		for (int i = 0; i < 3; i++) begin
			dmag[i] = d_s1[i][DW-1] ? DW'(-d_s1[i]) : DW'(d_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOLW'(1);
		end else if (cfg.valid) begin
			tol_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= query.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s1[i]  <= in_a[i];
				b_s1[i]  <= in_b[i];
				p_s1[i]  <= in_p[i];
				d_s1[i]  <= DW'(in_b[i]) - DW'(in_a[i]);
				pa_s1[i] <= DW'(in_p[i]) - DW'(in_a[i]);

				a_s2[i]  <= a_s1[i];
				b_s2[i]  <= b_s1[i];
				p_s2[i]  <= p_s1[i];
				dd_s2[i] <= d_s1[i] * d_s1[i];
				pd_s2[i] <= pa_s1[i] * d_s1[i];
				dm_s2[i] <= dmag[i][CW-1:0];
				dn_s2[i] <= d_s1[i][DW-1];

				a_s3[i]  <= a_s2[i];
				b_s3[i]  <= b_s2[i];
				p_s3[i]  <= p_s2[i];
				dm_s3[i] <= dm_s2[i];
			end
			small_s2 <= (dmag[0] < DW'(tol_q)) && (dmag[1] < DW'(tol_q))
				&& (dmag[2] < DW'(tol_q));
			zero_s2  <= (d_s1[0] == '0) && (d_s1[1] == '0) && (d_s1[2] == '0);

			dn_s3    <= dn_s2;
			den_s3   <= $unsigned(dd_s2[0]) + $unsigned(dd_s2[1]) + $unsigned(dd_s2[2]);
			num_s3   <= NUMW'(pd_s2[0]) + NUMW'(pd_s2[1]) + NUMW'(pd_s2[2]);
			degen_s3 <= small_s2 || zero_s2;

			// Compare the numerator with the denominator instead of dividing.
			priority if (degen_s3) begin
				ent_s4.status <= ST_DEGEN;
				ent_s4.base   <= '0;
			end else if (num_s3[NUMW-1]) begin
				ent_s4.status <= ST_ENDPOINT;
				for (int i = 0; i < 3; i++) ent_s4.base[i] <= a_s3[i];
			end else if ($signed(num_s3) > $signed({1'b0, den_s3})) begin
				ent_s4.status <= ST_ENDPOINT;
				for (int i = 0; i < 3; i++) ent_s4.base[i] <= b_s3[i];
			end else begin
				ent_s4.status <= ST_FOOT;
				for (int i = 0; i < 3; i++) ent_s4.base[i] <= a_s3[i];
			end
			for (int i = 0; i < 3; i++) begin
				ent_s4.query[i] <= p_s3[i];
				ent_s4.d_mag[i] <= dm_s3[i];
			end
			ent_s4.d_neg <= dn_s3;
			ent_s4.num   <= num_s3[DENW-1:0];
			ent_s4.den   <= den_s3;
		end
	end

endmodule
`default_nettype wire

[design/ptsn_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptsn_queue: short queue between front end and back end
// A two-entry register queue that lets either side stall on its own.
// ----------------------------------------------------------------------------
module ptsn_queue import ptsn_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  qent_t push_data,
	input  logic  push_valid,
	output logic  push_ready,
	output qent_t pop_data,
	output logic  pop_valid,
	input  logic  pop_ready
);

	qent_t            mem_q [QDEPTH];
	logic [QAW-1:0]   wr_q, rd_q;
	logic [QCW-1:0]   count_q;
	logic             push, pop;

	assign push_ready = count_q != QCW'(QDEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH)) else $error("queue count above depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1) else $error("push lost");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> count_q == $past(count_q) - 1'b1) else $error("pop lost");
	a_empty_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wr_q == rd_q) else $error("pointers disagree when empty");

endmodule
`default_nettype wire

[design/ptsn_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptsn_back: foot point, distance and output register
// Split product, a bit-per-stage divider for the foot offset, the squared
// distance and a bit-per-stage square root, all under one stall enable.
// ----------------------------------------------------------------------------
module ptsn_back import ptsn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  qent_t         ent,
	input  logic          ent_valid,
	output logic          ent_ready,
	ptsn_result_if.source result
);

	typedef struct packed {
		status_t    status;
		vec_t       base;
		vec_t       query;
		logic [2:0] d_neg;
	} side_t;

	logic en;

	// product stage
	logic                 v_s1;
	side_t                sd_s1;
	logic [CW+HW-1:0]     plo_s1 [3], phi_s1 [3];
	logic [DENW-1:0]      den_s1;

	// divider stages, index 0 holds the dividend and divisor
	logic                 div_v_q   [CW+1];
	side_t                div_sd_q  [CW+1];
	logic [DVW-1:0]       div_rem_q [CW+1][3];
	logic [CW-1:0]        div_low_q [CW+1][3];
	logic [CW-1:0]        div_quo_q [CW+1][3];
	logic [DVW-1:0]       div_dv_q  [CW+1];
	logic [DVW-1:0]       div_rem_n [CW][3];
	logic [CW-1:0]        div_low_n [CW][3];
	logic [CW-1:0]        div_quo_n [CW][3];
	logic [NWID-1:0]      dividend  [3];

	// foot and square stages
	logic                 v_s2, v_s3;
	side_t                sd_s2, sd_s3;
	logic signed [DW-1:0] e_s2 [3];
	logic signed [SQW-1:0] sq_s3 [3];
	coord_t               near_w [3];
	logic signed [DW-1:0] e_w [3];

	// root stages, index 0 holds the squared distance
	logic                 rt_v_q    [RW+1];
	side_t                rt_sd_q   [RW+1];
	logic [SQW-1:0]       rt_rem_q  [RW+1];
	logic [RW-1:0]        rt_root_q [RW+1];
	logic [SQW-1:0]       rt_rem_n  [RW];
	logic [RW-1:0]        rt_root_n [RW];

	logic                 out_v_q;
	side_t                out_sd_q;
	logic [RW-1:0]        out_dist_q;

	assign en        = !out_v_q || result.ready;
	assign ent_ready = en;

	always_comb begin
		logic [TW-1:0]  t;
		logic [DVW:0]   sh;
		logic [SQW-1:0] trial;
		int             b;
		for (int i = 0; i < 3; i++) begin
			t = TW'(plo_s1[i]) + (TW'(phi_s1[i]) << HW);
			dividend[i] = {t, 1'b0} + NWID'(den_s1);
		end
		for (int j = 1; j <= CW; j++) begin
			for (int i = 0; i < 3; i++) begin
				sh = {div_rem_q[j-1][i], div_low_q[j-1][i][CW-1]};
				div_low_n[j-1][i] = {div_low_q[j-1][i][CW-2:0], 1'b0};
				if (sh >= {1'b0, div_dv_q[j-1]}) begin
					div_rem_n[j-1][i] = DVW'(sh - {1'b0, div_dv_q[j-1]});
					div_quo_n[j-1][i] = {div_quo_q[j-1][i][CW-2:0], 1'b1};
				end else begin
					div_rem_n[j-1][i] = sh[DVW-1:0];
					div_quo_n[j-1][i] = {div_quo_q[j-1][i][CW-2:0], 1'b0};
				end
			end
		end
		for (int i = 0; i < 3; i++) begin
			if (div_sd_q[CW].status == ST_FOOT) begin
				if (div_sd_q[CW].d_neg[i]) begin
					near_w[i] = coord_t'(DW'($signed(div_sd_q[CW].base[i]))
						- $signed({1'b0, div_quo_q[CW][i]}));
				end else begin
					near_w[i] = coord_t'(DW'($signed(div_sd_q[CW].base[i]))
						+ $signed({1'b0, div_quo_q[CW][i]}));
				end
			end else begin
				near_w[i] = div_sd_q[CW].base[i];
			end
			e_w[i] = DW'($signed(div_sd_q[CW].query[i])) - DW'(near_w[i]);
		end
		for (int j = 1; j <= RW; j++) begin
			b = RW - j;
			trial = (SQW'(rt_root_q[j-1]) << (b + 1)) | (SQW'(1) << (2 * b));
			if (trial <= rt_rem_q[j-1]) begin
				rt_rem_n[j-1]  = rt_rem_q[j-1] - trial;
				rt_root_n[j-1] = rt_root_q[j-1] | (RW'(1) << b);
			end else begin
				rt_rem_n[j-1]  = rt_rem_q[j-1];
				rt_root_n[j-1] = rt_root_q[j-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
			for (int j = 0; j <= CW; j++) div_v_q[j] <= 1'b0;
			for (int j = 0; j <= RW; j++) rt_v_q[j] <= 1'b0;
		end else if (en) begin
			v_s1       <= ent_valid;
			div_v_q[0] <= v_s1;
			for (int j = 1; j <= CW; j++) div_v_q[j] <= div_v_q[j-1];
			v_s2       <= div_v_q[CW];
			v_s3       <= v_s2;
			rt_v_q[0]  <= v_s3;
			for (int j = 1; j <= RW; j++) rt_v_q[j] <= rt_v_q[j-1];
			out_v_q    <= rt_v_q[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.status <= ent.status;
			sd_s1.base   <= ent.base;
			sd_s1.query  <= ent.query;
			sd_s1.d_neg  <= ent.d_neg;
			den_s1       <= ent.den;
			for (int i = 0; i < 3; i++) begin
				plo_s1[i] <= ent.d_mag[i] * ent.num[HW-1:0];
				phi_s1[i] <= ent.d_mag[i] * ent.num[DENW-1:HW];
			end

			div_sd_q[0] <= sd_s1;
			div_dv_q[0] <= {den_s1, 1'b0};
			for (int i = 0; i < 3; i++) begin
				div_rem_q[0][i] <= dividend[i][NWID-1:CW];
				div_low_q[0][i] <= dividend[i][CW-1:0];
				div_quo_q[0][i] <= '0;
			end
			for (int j = 1; j <= CW; j++) begin
				div_sd_q[j] <= div_sd_q[j-1];
				div_dv_q[j] <= div_dv_q[j-1];
				for (int i = 0; i < 3; i++) begin
					div_rem_q[j][i] <= div_rem_n[j-1][i];
					div_low_q[j][i] <= div_low_n[j-1][i];
					div_quo_q[j][i] <= div_quo_n[j-1][i];
				end
			end

			sd_s2.status <= div_sd_q[CW].status;
			sd_s2.query  <= div_sd_q[CW].query;
			sd_s2.d_neg  <= div_sd_q[CW].d_neg;
			for (int i = 0; i < 3; i++) begin
				sd_s2.base[i] <= near_w[i];
				e_s2[i]       <= e_w[i];
				sq_s3[i]      <= e_s2[i] * e_s2[i];
			end
			sd_s3 <= sd_s2;

			rt_sd_q[0]   <= sd_s3;
			rt_rem_q[0]  <= $unsigned(sq_s3[0]) + $unsigned(sq_s3[1]) + $unsigned(sq_s3[2]);
			rt_root_q[0] <= '0;
			for (int j = 1; j <= RW; j++) begin
				rt_sd_q[j]   <= rt_sd_q[j-1];
				rt_rem_q[j]  <= rt_rem_n[j-1];
				rt_root_q[j] <= rt_root_n[j-1];
			end

			out_sd_q   <= rt_sd_q[RW];
			out_dist_q <= (rt_sd_q[RW].status == ST_DEGEN) ? '0 : rt_root_q[RW];
		end
	end

	assign result.valid        = out_v_q;
	assign result.status       = out_sd_q.status;
	assign result.near_x       = out_sd_q.base[0];
	assign result.near_y       = out_sd_q.base[1];
	assign result.near_z       = out_sd_q.base[2];
	assign result.min_distance = out_dist_q;

endmodule
`default_nettype wire

[design/point_to_segment_nearest_3d.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_to_segment_nearest_3d: nearest point on a 3-D segment and distance
// Pipelined block that takes segment endpoints and a query point per item
// and returns a status, the nearest point and the truncated distance.
// ----------------------------------------------------------------------------
// Use of the block:
//   The query channel carries one item per handshake: endpoints A and B and
//   the query point P, signed fixed point. An item is taken at a rising edge
//   where valid and ready are both high. The result channel returns, in the
//   same order, one item per query: status, nearest point and distance.
//   The configuration channel writes the degenerate tolerance; it is always
//   ready and should be written only while no item is in flight.
//   Throughput is one item per cycle when nothing stalls. Most of the depth
//   lies in the divider for the foot offset (one quotient bit per stage)
//   and the square root (one root bit per stage) in the back end.
//   When the receiver holds ready low, the back end freezes and the result
//   stays on the port; the front end keeps accepting until the two-entry
//   queue between the halves is full and the last of its four stages holds
//   an item, and only then drops query ready.
//   Reset clears all valid flags and the queue and loads the tolerance
//   with one; no clearing pass is needed, so items are taken at once.
// ----------------------------------------------------------------------------
module point_to_segment_nearest_3d import ptsn_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	ptsn_query_if.sink    query,
	ptsn_result_if.source result,
	ptsn_cfg_if.sink      cfg
);

	// The front end classifies each item and hands it over with the dot
	// products it has formed; the back end does the long arithmetic.
	qent_t front_ent, back_ent;
	logic  front_valid, front_ready;
	logic  back_valid, back_ready;

	ptsn_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.query     (query),
		.cfg       (cfg),
		.ent       (front_ent),
		.ent_valid (front_valid),
		.ent_ready (front_ready)
	);

	// The queue decouples the two halves so that a stall on the result side
	// does not reach the query side at once.
	ptsn_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (front_ent),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.pop_data   (back_ent),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready)
	);

	ptsn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.ent       (back_ent),
		.ent_valid (back_valid),
		.ent_ready (back_ready),
		.result    (result)
	);

endmodule
`default_nettype wire

[tb/tb_ptsn_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ptsn_pkg: item types for the segment nearest-point testbench
// Holds the query and result items as the testbench stores them.
// ----------------------------------------------------------------------------
package tb_ptsn_pkg;
	import ptsn_pkg::*;

	typedef struct {
		logic signed [CW-1:0] a [3];
		logic signed [CW-1:0] b [3];
		logic signed [CW-1:0] p [3];
	} seg_query_t;

	typedef struct {
		status_t              status;
		logic signed [CW-1:0] near [3];
		logic [CW:0]          distance;
	} nearest_t;
endpackage

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for point_to_segment_nearest_3d
// Drives directed and random segment queries, predicts the status, nearest
// point and distance of each one and compares every result item in order.
// ----------------------------------------------------------------------------
module tb_top;
	import ptsn_pkg::*;
	import tb_ptsn_pkg::*;

	// Drain allowance after the expected queue empties is generous.
	localparam int DRAIN_CYCLES = 200;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int N_RANDOM     = 495;
	localparam logic [TOLW-1:0] TOL_MAX = {TOLW{1'b1}};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ptsn_query_if  query ();
	ptsn_result_if result ();
	ptsn_cfg_if    cfg ();

	point_to_segment_nearest_3d dut (
		.clk   (clk),
		.arst_n(arst_n),
		.query (query.sink),
		.result(result.source),
		.cfg   (cfg.sink)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Predictor state: the tolerance register as the block should hold it.
	logic [TOLW-1:0] tolerance;

	nearest_t expected_q [$];
	int  mismatches = 0;
	int  cycles = 0;
	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	bit  hold_off = 1'b0;
	int  hold_cycles = 0;

	// Nearest point on segment AB to P, with the distance, computed in wide
	// integers: num = (P-A).D and den = |D|^2 are compared rather than divided.
	function automatic nearest_t predict_nearest(seg_query_t q);
		nearest_t r;
		logic signed [127:0] d [3];
		logic signed [127:0] num, den, sq, e, t;
		logic [127:0] mag, off, root, cand;
		bit all_small, all_zero;
		all_small = 1'b1;
		all_zero  = 1'b1;
		num = 0;
		den = 0;
		sq  = 0;
		for (int i = 0; i < 3; i++) begin
			d[i] = 128'(signed'(q.b[i])) - 128'(signed'(q.a[i]));
			mag = d[i] < 0 ? -d[i] : d[i];
			if (mag >= 128'(tolerance))
				all_small = 1'b0;
			if (d[i] != 0)
				all_zero = 1'b0;
		end
		r.near = '{default: '0};
		r.distance = '0;
		if (all_small || all_zero) begin
			r.status = ST_DEGEN;
			return r;
		end
		for (int i = 0; i < 3; i++) begin
			den += d[i] * d[i];
			num += (128'(signed'(q.p[i])) - 128'(signed'(q.a[i]))) * d[i];
		end
		if (num < 0) begin
			r.status = ST_ENDPOINT;
			r.near = q.a;
		end else if (num > den) begin
			r.status = ST_ENDPOINT;
			r.near = q.b;
		end else begin
			r.status = ST_FOOT;
			for (int i = 0; i < 3; i++) begin
				mag = d[i] < 0 ? -d[i] : d[i];
				// Offset rounded to nearest, ties away from A.
				off = (2 * mag * num + den) / (2 * den);
				t = d[i] < 0 ? 128'(signed'(q.a[i])) - off : 128'(signed'(q.a[i])) + off;
				r.near[i] = t[CW-1:0];
			end
		end
		for (int i = 0; i < 3; i++) begin
			e = 128'(signed'(q.p[i])) - 128'(signed'(r.near[i]));
			sq += e * e;
		end
		root = 0;
		for (int bitpos = 63; bitpos >= 0; bitpos--) begin
			cand = root | (128'd1 << bitpos);
			if (cand * cand <= sq)
				root = cand;
		end
		r.distance = root > {CW+1{1'b1}} ? {CW+1{1'b1}} : root[CW:0];
		return r;
	endfunction

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
			1: return CW'($signed($urandom_range(0, 64)) - 32);
			2: return CW'($signed($urandom_range(0, 8192)) - 4096);
			default: return CW'($urandom);
		endcase
	endfunction

	function automatic seg_query_t rand_query();
		seg_query_t q;
		for (int i = 0; i < 3; i++) begin
			q.a[i] = rand_coord();
			q.p[i] = rand_coord();
			case ($urandom_range(0, 9))
				0: q.b[i] = q.a[i];
				1: q.b[i] = q.a[i] + CW'($signed($urandom_range(0, 6)) - 3);
				default: q.b[i] = rand_coord();
			endcase
		end
		return q;
	endfunction

	// Sender: offers one query item and waits for it to be taken. Valid is
	// dropped only while idling, so items can follow with no gap.
	task automatic send_query(seg_query_t q);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
			query.valid <= 1'b0;
			@(posedge clk);
		end
		query.valid   <= 1'b1;
		query.seg_a_x <= q.a[0]; query.seg_a_y <= q.a[1]; query.seg_a_z <= q.a[2];
		query.seg_b_x <= q.b[0]; query.seg_b_y <= q.b[1]; query.seg_b_z <= q.b[2];
		query.query_x <= q.p[0]; query.query_y <= q.p[1]; query.query_z <= q.p[2];
		expected_q.push_back(predict_nearest(q));
		do @(posedge clk); while (!query.ready);
	endtask

	task automatic write_tolerance(logic [TOLW-1:0] value);
		cfg.valid <= 1'b1;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		tolerance = value;
	endtask

	task automatic wait_idle();
		query.valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Receiver: ready is redrawn every cycle, or held low during a hold-off.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result.ready <= 1'b0;
		end else if (hold_off) begin
			hold_cycles <= 300;
			result.ready <= 1'b0;
		end else begin
			result.ready <= !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Checker: every accepted result is compared with the oldest prediction.
	always @(posedge clk) begin
		nearest_t want;
		if (arst_n && result.valid && result.ready) begin
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item at cycle %0d", cycles);
			end else begin
				want = expected_q.pop_front();
				if (result.status !== want.status || result.near_x !== want.near[0] ||
					result.near_y !== want.near[1] || result.near_z !== want.near[2] ||
					result.min_distance !== want.distance) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: got %0d (%0d %0d %0d) %0d, want %0d (%0d %0d %0d) %0d",
							result.status, result.near_x, result.near_y, result.near_z,
							result.min_distance, want.status, want.near[0], want.near[1],
							want.near[2], want.distance);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("point_to_segment_nearest_3d test failed");
			$finish;
		end
	end

	// Directed table: a, b, p, and whether the expectation is typed in.
	typedef struct {
		logic signed [CW-1:0] a [3];
		logic signed [CW-1:0] b [3];
		logic signed [CW-1:0] p [3];
		bit                   typed;
		nearest_t             want;
	} dir_row_t;

	dir_row_t dir_rows [$];

	task automatic add_row(int ax, int ay, int az, int bx, int by, int bz,
			int px, int py, int pz, bit typed, status_t st, int nx, int ny, int nz,
			int distance);
		dir_row_t r;
		r.a = '{CW'(ax), CW'(ay), CW'(az)};
		r.b = '{CW'(bx), CW'(by), CW'(bz)};
		r.p = '{CW'(px), CW'(py), CW'(pz)};
		r.typed = typed;
		r.want.status = st;
		r.want.near = '{CW'(nx), CW'(ny), CW'(nz)};
		r.want.distance = (CW+1)'(distance);
		dir_rows.push_back(r);
	endtask

	initial begin
		seg_query_t q;
		nearest_t   got;
		int         lo, hi;
		query.valid = 1'b0;
		query.seg_a_x = '0; query.seg_a_y = '0; query.seg_a_z = '0;
		query.seg_b_x = '0; query.seg_b_y = '0; query.seg_b_z = '0;
		query.query_x = '0; query.query_y = '0; query.query_z = '0;
		result.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		tolerance = 1;
		lo = -8388608;
		hi = 8388607;

		// Identical endpoints with the reset tolerance: degenerate, all zero.
		add_row(5, 6, 7, 5, 6, 7, 100, 100, 100, 1, ST_DEGEN, 0, 0, 0, 0);
		// Segment on x from 0 to 4096, query beyond each end and in the middle.
		add_row(0, 0, 0, 4096, 0, 0, -4096, 0, 0, 1, ST_ENDPOINT, 0, 0, 0, 4096);
		add_row(0, 0, 0, 4096, 0, 0, 8192, 0, 0, 1, ST_ENDPOINT, 4096, 0, 0, 4096);
		add_row(0, 0, 0, 4096, 0, 0, 2048, 3000, 0, 1, ST_FOOT, 2048, 0, 0, 3000);
		// Foot exactly on A and on B counts as on the segment.
		add_row(0, 0, 0, 4096, 0, 0, 0, 0, 4000, 1, ST_FOOT, 0, 0, 0, 4000);
		add_row(0, 0, 0, 4096, 0, 0, 4096, 4000, 0, 1, ST_FOOT, 4096, 0, 0, 4000);
		// Extremes of the coordinate range.
		add_row(lo, lo, lo, hi, hi, hi, lo, hi, lo, 0, ST_DEGEN, 0, 0, 0, 0);
		add_row(hi, hi, hi, lo, lo, lo, hi, lo, hi, 0, ST_DEGEN, 0, 0, 0, 0);
		add_row(lo, lo, lo, lo, lo, hi, hi, hi, hi, 0, ST_DEGEN, 0, 0, 0, 0);
		add_row(hi, lo, hi, lo, hi, lo, lo, lo, lo, 0, ST_DEGEN, 0, 0, 0, 0);
		add_row(lo, lo, lo, lo, lo, lo, hi, hi, hi, 1, ST_DEGEN, 0, 0, 0, 0);
		// Odd tie cases for the rounding of the foot.
		add_row(0, 0, 0, 3, 1, 0, 1, 2, 0, 0, ST_DEGEN, 0, 0, 0, 0);
		add_row(10, -10, 3, -7, 9, -5, 1, 1, 1, 0, ST_DEGEN, 0, 0, 0, 0);
		add_row(-1, -1, -1, 0, 0, 0, 5, -5, 2, 0, ST_DEGEN, 0, 0, 0, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			q.a = dir_rows[i].a;
			q.b = dir_rows[i].b;
			q.p = dir_rows[i].p;
			got = predict_nearest(q);
			if (dir_rows[i].typed && (got.status != dir_rows[i].want.status ||
				got.near != dir_rows[i].want.near ||
				got.distance != dir_rows[i].want.distance))
				$display("directed row %0d disagrees with the predictor", i);
			send_query(q);
		end
		wait_idle();

		// Tolerance sweep: largest first, so nearly everything is degenerate.
		write_tolerance(TOL_MAX);
		q.a = dir_rows[1].a;
		q.b = dir_rows[1].b;
		q.p = dir_rows[1].p;
		send_query(q);
		for (int i = 0; i < 20; i++)
			send_query(rand_query());
		wait_idle();
		write_tolerance(0);
		for (int i = 0; i < 20; i++)
			send_query(rand_query());
		wait_idle();
		write_tolerance(4096);

		// Random phases with the three idling patterns; one long hold-off.
		send_idle_pct = 14;
		recv_idle_pct = 47;
		for (int i = 0; i < N_RANDOM / 3; i++) begin
			if (i == 40)
				hold_off <= 1'b1;
			if (i == 41)
				hold_off <= 1'b0;
			send_query(rand_query());
		end
		wait_idle();
		write_tolerance(TOLW'($urandom_range(0, 64)));
		send_idle_pct = 47;
		recv_idle_pct = 14;
		for (int i = 0; i < N_RANDOM / 3; i++)
			send_query(rand_query());
		wait_idle();
		write_tolerance(1);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		for (int i = 0; i < N_RANDOM / 3; i++)
			send_query(rand_query());
		wait_idle();

		if (mismatches == 0)
			$display("point_to_segment_nearest_3d test passed");
		else
			$display("point_to_segment_nearest_3d test failed");
		$finish;
	end
endmodule
